[rtl/core/cfp_pkg.sv]
// shared types, constants and helpers for the clamped float power block
`default_nettype none
package cfp_pkg;

    typedef struct packed {
        logic [31:0]        value_bits;
        logic signed [7:0]  power;
        logic               last_element;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        last_out;
    } out_word_t;

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_PASS = 2'd1,
        KIND_MULT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value_bits;
        logic        last_element;
    } job_t;

    localparam logic [31:0] ONE_BITS   = 32'h3F80_0000;
    localparam logic [31:0] CLAMP_BITS = 32'h411F_FFFF;
    localparam logic [31:0] QNAN_BITS  = 32'hFFC0_0000;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;

    // position of the leading one in a 48-bit product
    function automatic logic [5:0] lead_one48(input logic [47:0] v);
        logic [5:0] pos;
        pos = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

[rtl/core/cfp_front.sv]
// front end: classifies words, saturates the exponent and queues jobs
`default_nettype none
module cfp_front
    import cfp_pkg::*;
#(
    parameter int MAX_POWER = 127,
    parameter int CW        = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire in_word_t      in_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output job_t               q_job,
    output logic [CW-1:0]      q_steps
);

    job_t          job_mem [2];
    logic [CW-1:0] steps_mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push, pop;
    job_t          new_job;
    logic [16:0]   steps_wide;
    logic          is_nan;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_job    = job_mem[rd_ptr_reg];
    assign q_steps  = steps_mem[rd_ptr_reg];

    assign is_nan = (in_data.value_bits[30:23] == EXP_MAX) && (in_data.value_bits[22:0] != 23'd0);

    always_comb
    begin
        new_job.value_bits   = in_data.value_bits;
        new_job.last_element = in_data.last_element;
        steps_wide           = 17'd1;
        if (in_data.power == 8'sd0)
        begin
            new_job.kind = KIND_UNIT;
            steps_wide   = 17'd0;
        end
        else if (is_nan)
        begin
            new_job.kind = KIND_PASS;
        end
        else
        begin
            new_job.kind = KIND_MULT;
            if (in_data.power > 8'sd0)
            begin
                // saturate to the largest allowed step count
                if ({9'd0, in_data.power[7:0]} > 17'(MAX_POWER))
                begin
                    steps_wide = 17'(MAX_POWER);
                end
                else
                begin
                    steps_wide = {9'd0, in_data.power[7:0]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            job_mem[wr_ptr_reg]   <= new_job;
            steps_mem[wr_ptr_reg] <= steps_wide[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/cfp_back.sv]
// back end: repeated single-precision multiply with rounding and clamp
`default_nettype none
module cfp_back
    import cfp_pkg::*;
#(
    parameter int CW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire job_t          q_job,
    input  wire logic [CW-1:0] q_steps,
    output logic               out_valid,
    input  wire logic          out_ready,
    output out_word_t          out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_LZC  = 4'b0100,
        S_RND  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic          out_valid_reg;
    out_word_t     out_data_reg;
    logic [31:0]   acc_reg, base_reg;
    logic [CW-1:0] cnt_reg;
    logic          last_reg;
    logic [47:0]   prod_reg;
    logic [9:0]    esum_reg;
    logic          sign_reg, zero_reg, inf_reg;
    logic [5:0]    lead_reg;
    logic          out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign q_ready   = (state_reg == S_IDLE) && q_valid
                       && (q_job.kind == KIND_MULT || out_free);

    // operand unpack for the multiply step
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    always_comb
    begin
        ea = (acc_reg[30:23] == 8'd0) ? 8'd1 : acc_reg[30:23];
        eb = (base_reg[30:23] == 8'd0) ? 8'd1 : base_reg[30:23];
        ma = {acc_reg[30:23] != 8'd0, acc_reg[22:0]};
        mb = {base_reg[30:23] != 8'd0, base_reg[22:0]};
    end

    // normalize and round to nearest even
    logic signed [11:0] re, sh;
    logic [6:0]         ls, rs;
    logic [95:0]        wide;
    logic [47:0]        top;
    logic               sticky, inc;
    logic [7:0]         expf;
    logic [30:0]        mag;
    logic [31:0]        rnd_bits, final_bits;
    always_comb
    begin
        re = $signed({2'b00, esum_reg}) + $signed({6'd0, lead_reg}) - 12'sd173;
        if (re >= 12'sd1)
        begin
            sh   = 12'sd47 - $signed({6'd0, lead_reg});
            expf = re[7:0];
        end
        else
        begin
            sh   = 12'sd47 - $signed({6'd0, lead_reg}) - (12'sd1 - re);
            expf = 8'd0;
        end
        ls = 7'd0;
        rs = 7'd0;
        if (sh >= 12'sd0)
        begin
            ls = sh[6:0];
        end
        else if (-sh > 12'sd48)
        begin
            rs = 7'd48;
        end
        else
        begin
            rs = 7'((-sh));
        end
        if (sh >= 12'sd0)
        begin
            wide = {prod_reg, 48'd0} << ls;
        end
        else
        begin
            wide = {prod_reg, 48'd0} >> rs;
        end
        top    = wide[95:48];
        sticky = (|top[22:0]) || (|wide[47:0]);
        inc    = top[23] && (sticky || top[24]);
        mag    = {expf, top[46:24]} + {30'd0, inc};
        if (inf_reg)
        begin
            rnd_bits = zero_reg ? QNAN_BITS : {sign_reg, EXP_MAX, 23'd0};
        end
        else if (zero_reg)
        begin
            rnd_bits = {sign_reg, 31'd0};
        end
        else if (re >= 12'sd255)
        begin
            rnd_bits = {sign_reg, EXP_MAX, 23'd0};
        end
        else
        begin
            rnd_bits = {sign_reg, mag};
        end
        // upper clamp, positive values only
        if (!rnd_bits[31] && rnd_bits[30:0] > CLAMP_BITS[30:0])
        begin
            final_bits = CLAMP_BITS;
        end
        else
        begin
            final_bits = rnd_bits;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_ready && q_job.kind == KIND_MULT)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_LZC;
            S_LZC:   state_next = S_RND;
            S_RND:
            begin
                if (cnt_reg != CW'(1))
                begin
                    state_next = S_MUL;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_ready)
        begin
            acc_reg  <= ONE_BITS;
            base_reg <= q_job.value_bits;
            cnt_reg  <= q_steps;
            last_reg <= q_job.last_element;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= ma * mb;
            esum_reg <= {2'b00, ea} + {2'b00, eb};
            sign_reg <= acc_reg[31] ^ base_reg[31];
            zero_reg <= (ma == 24'd0) || (mb == 24'd0);
            inf_reg  <= (acc_reg[30:23] == EXP_MAX) || (base_reg[30:23] == EXP_MAX);
        end
        if (state_reg == S_LZC)
        begin
            lead_reg <= lead_one48(prod_reg);
        end
        if (state_reg == S_RND && cnt_reg != CW'(1))
        begin
            acc_reg <= rnd_bits;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (state_reg == S_IDLE && q_ready && q_job.kind != KIND_MULT)
        begin
            out_data_reg.result_bits <= (q_job.kind == KIND_UNIT) ? ONE_BITS
                                                                  : q_job.value_bits;
            out_data_reg.last_out    <= q_job.last_element;
        end
        else if (state_reg == S_RND && cnt_reg == CW'(1) && out_free)
        begin
            out_data_reg.result_bits <= final_bits;
            out_data_reg.last_out    <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE && q_ready && q_job.kind != KIND_MULT)
                || (state_reg == S_RND && cnt_reg == CW'(1) && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/clamped_float_power.sv]
// top level: integer power of a single-precision value with upper clamp
// a zero exponent or a nan base skips the multiply loop; other words run the shared
// multiply/normalize/round loop once per step, and it takes no new word until it is done
// with the last step; a two-word queue lets the front accept meanwhile
// reset: rst_n async active low clears queue, sequencer and output valid
`default_nettype none
module clamped_float_power
    import cfp_pkg::*;
#(
    parameter int MAX_POWER = 127
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_word_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_word_t     out_data
);

    // step counter width follows the largest exponent
    localparam int CW = $clog2(MAX_POWER + 1);

    // queue between classifier and multiply loop
    logic          q_valid;
    logic          q_ready;
    job_t          q_job;
    logic [CW-1:0] q_steps;

    // front: zero exponent, nan base and step count decided here
    cfp_front #(
        .MAX_POWER (MAX_POWER),
        .CW        (CW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_job    (q_job),
        .q_steps  (q_steps)
    );

    // back: multiply, leading-one search, round per step, then clamp
    cfp_back #(
        .CW (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_job     (q_job),
        .q_steps   (q_steps),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

[tb/clamped_float_power_tb.sv]
// self-checking testbench for the clamped float power block
`timescale 1ns / 100ps
`default_nettype none
module clamped_float_power_tb;
    import cfp_pkg::*;

    localparam int MAX_POW    = 127;
    localparam int N_RANDOM   = 1500;
    localparam int LONG_HOLD  = 900;
    localparam int DRAIN_WAIT = 3 * MAX_POW + 20;
    localparam int IN_W       = $bits(in_word_t);

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    clamped_float_power #(.MAX_POWER(MAX_POW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // expected result words, oldest first
    out_word_t expected_words[$];
    int        n_errors;
    int        n_checked;
    int        n_clamped;
    int        n_sent;
    bit        hold_now;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ---------------------------------------------------------------
    // single-precision multiply, round to nearest even
    // ---------------------------------------------------------------
    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        sgn;
        logic        a_inf, b_inf, a_zero, b_zero, sticky;
        logic [23:0] ma, mb, keep;
        logic [47:0] m;
        int          ea, eb, e, sh;
        sgn    = a[31] ^ b[31];
        a_inf  = (a[30:23] == 8'hFF);
        b_inf  = (b[30:23] == 8'hFF);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_inf || b_inf)
        begin
            if (a_zero || b_zero)
                return QNAN_BITS;
            return {sgn, 8'hFF, 23'd0};
        end
        if (a_zero || b_zero)
            return {sgn, 31'd0};
        // unpack, subnormals get the low exponent and no hidden bit
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        ma = {(a[30:23] != 0), a[22:0]};
        mb = {(b[30:23] != 0), b[22:0]};
        while (!ma[23])
        begin
            ma = ma << 1;
            ea = ea - 1;
        end
        while (!mb[23])
        begin
            mb = mb << 1;
            eb = eb - 1;
        end
        m = 48'(ma) * 48'(mb);
        e = ea + eb - 126;
        if (!m[47])
        begin
            m = m << 1;
            e = e - 1;
        end
        sticky = 1'b0;
        if (e < 1)
        begin
            // denormalize, folding lost bits into sticky
            sh = 1 - e;
            if (sh >= 48)
            begin
                sticky = |m;
                m = '0;
            end
            else
            begin
                sticky = |(m & ((48'd1 << sh) - 48'd1));
                m = m >> sh;
            end
            e = 0;
        end
        keep   = m[47:24];
        sticky = sticky | (|m[22:0]);
        if (m[23] && (sticky || keep[0]))
        begin
            if (keep == 24'hFF_FFFF)
            begin
                keep = 24'h80_0000;
                e = (e == 0) ? 1 : e + 1;
            end
            else
                keep = keep + 24'd1;
        end
        // rounding up out of the subnormal range lands on the smallest normal
        if (e == 0 && keep[23])
            e = 1;
        if (e >= 255)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, 8'(e), keep[22:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // expected word for one input word
    function automatic out_word_t predict_power(input in_word_t w);
        out_word_t   r;
        int          p, steps;
        logic [31:0] acc;
        p = int'(w.power);
        if (p == 0)
            steps = 0;
        else if (p < 0)
            steps = 1;
        else if (p > MAX_POW)
            steps = MAX_POW;
        else
            steps = p;
        if (steps == 0)
            acc = ONE_BITS;
        else if (is_nan(w.value_bits))
            acc = w.value_bits;
        else
        begin
            acc = ONE_BITS;
            for (int k = 0; k < steps; k++)
                acc = sp_mul(acc, w.value_bits);
            // upper clamp: positive, non-nan, above the limit
            if (!acc[31] && !is_nan(acc) && acc > CLAMP_BITS)
                acc = CLAMP_BITS;
        end
        r.result_bits = acc;
        r.last_out    = w.last_element;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // sender: offers one word, returns at the edge it was taken
    // ---------------------------------------------------------------
    task automatic offer_word(input in_word_t w, input bit typed,
                              input logic [31:0] typed_bits);
        out_word_t e;
        e = predict_power(w);
        if (typed)
            e.result_bits = typed_bits;
        expected_words.push_back(e);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= in_word_t'(IN_W'({$urandom, $urandom}));
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: v = v;
            3, 4, 5: v[30:23] = 8'd126 + 8'($urandom_range(0, 1));
            6:       v[30:23] = 8'd0;
            7:       v[30:23] = 8'hFF;
            8:       v[30:0]  = 31'd0;
            default: v[30:23] = 8'($urandom_range(120, 130));
        endcase
        return v;
    endfunction

    function automatic logic signed [7:0] random_power();
        case ($urandom_range(0, 9))
            0:       return 8'sd0;
            1, 2:    return 8'($urandom_range(128, 255));
            3, 4, 5: return 8'($urandom_range(1, 12));
            6:       return 8'sd127;
            default: return 8'($urandom);
        endcase
    endfunction

    typedef struct {
        in_word_t    w;
        bit          typed;
        logic [31:0] want;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{'{32'h4049_0FDB, 8'sd0,    1'b0}, 1'b1, ONE_BITS},    // zero exponent
        '{'{32'h7F80_0000, 8'sd0,    1'b1}, 1'b1, ONE_BITS},    // inf, zero exponent
        '{'{32'h7FC0_1234, 8'sd5,    1'b0}, 1'b1, 32'h7FC0_1234}, // nan passes through
        '{'{32'hFFFF_FFFF, 8'sd127,  1'b1}, 1'b1, 32'hFFFF_FFFF},
        '{'{32'h7F80_0001, -8'sd128, 1'b0}, 1'b1, 32'h7F80_0001},
        '{'{32'h42C8_0000, -8'sd1,   1'b1}, 1'b1, CLAMP_BITS},  // negative: base, clamped
        '{'{32'hC2C8_0000, -8'sd128, 1'b0}, 1'b1, 32'hC2C8_0000}, // no lower clamp
        '{'{32'h0000_0000, -8'sd128, 1'b1}, 1'b1, 32'h0000_0000},
        '{'{32'h4000_0000, 8'sd127,  1'b0}, 1'b1, CLAMP_BITS},  // saturated, clamped
        '{'{32'h7F80_0000, 8'sd1,    1'b1}, 1'b1, CLAMP_BITS},  // +inf clamps
        '{'{32'hFF80_0000, 8'sd3,    1'b0}, 1'b1, 32'hFF80_0000},
        '{'{32'hBF80_0000, 8'sd127,  1'b1}, 1'b1, 32'hBF80_0000},
        '{'{32'h7F7F_FFFF, 8'sd2,    1'b0}, 1'b1, CLAMP_BITS},  // overflow to inf, clamp
        '{'{32'h0000_0000, 8'sd5,    1'b1}, 1'b1, 32'h0000_0000},
        '{'{32'h411F_FFFF, 8'sd1,    1'b0}, 1'b1, CLAMP_BITS},  // exactly at limit
        '{'{32'h4120_0000, 8'sd1,    1'b1}, 1'b1, CLAMP_BITS},
        '{'{32'hFF7F_FFFF, 8'sd3,    1'b0}, 1'b0, 32'h0},
        '{'{32'hC040_0000, 8'sd3,    1'b1}, 1'b0, 32'h0},
        '{'{32'h0000_0001, 8'sd2,    1'b0}, 1'b0, 32'h0},       // subnormal underflow
        '{'{32'h3F00_0000, 8'sd127,  1'b1}, 1'b0, 32'h0},       // into subnormal range
        '{'{32'h3FC0_0000, 8'sd7,    1'b0}, 1'b0, 32'h0},
        '{'{32'h3F66_6666, 8'sd100,  1'b1}, 1'b0, 32'h0},
        '{'{32'h7F80_0000, -8'sd7,   1'b0}, 1'b1, CLAMP_BITS},
        '{'{32'h807F_FFFF, 8'sd1,    1'b1}, 1'b1, 32'h807F_FFFF}
    };

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        n_errors  = 0;
        n_checked = 0;
        n_clamped = 0;
        n_sent    = 0;
        hold_now  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (directed[i])
            offer_word(directed[i].w, directed[i].typed, directed[i].want);

        // random part: bursts with gaps between them
        while (n_sent < directed.size() + N_RANDOM)
        begin
            int burst;
            in_word_t w;
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                w.value_bits   = random_value();
                w.power        = random_power();
                w.last_element = 1'($urandom_range(0, 1));
                if (n_sent == directed.size() + 300)
                    hold_now = 1'b1;
                offer_word(w, 1'b0, 32'h0);
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        end
        in_valid <= 1'b0;

        // drain
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d words (%0d directed), %0d results checked, %0d clamped",
                 n_sent, directed.size(), n_checked, n_clamped);
        $display("including a long output hold-off and random bursts on both sides");
        if (n_errors == 0 && expected_words.size() == 0)
            $display("clamped_float_power_tb: PASS");
        else
            $display("clamped_float_power_tb: FAIL");
        $finish;
    end

    // receiver: stall pattern picked at random from four modes, plus one long hold-off
    initial
    begin
        int cyc;
        int mode;
        out_ready = 1'b0;
        cyc  = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 200 == 0)
                mode = $urandom_range(0, 3);
            if (hold_now)
            begin
                // hold long enough for the block and its queue to fill
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_now = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ((cyc % 5) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected word", out_data.result_bits, 32'h0);
            end
            else
            begin
                out_word_t e;
                e = expected_words.pop_front();
                n_checked++;
                if (e.result_bits == CLAMP_BITS)
                    n_clamped++;
                if (out_data.result_bits !== e.result_bits)
                    report_mismatch("result_bits", out_data.result_bits, e.result_bits);
                if (out_data.last_out !== e.last_out)
                    report_mismatch("last_out", 32'(out_data.last_out), 32'(e.last_out));
            end
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("clamped_float_power_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
